// ===== rtl/swm_pkg.sv =====
// swm_pkg: shared types, sizes and helpers for the sliding-window minimum block
// depends on nothing; used by swm_cell and sliding_window_minimum_core
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX  = 64;
    localparam int SAMPLE_BITS = 32;
    localparam int WSIZE_BITS  = 7;
    // age of a candidate never exceeds WINDOW_MAX
    localparam int AGE_BITS    = $clog2(WINDOW_MAX + 1);

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          last_in;
    } in_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] window_min;
        logic                          last_out;
    } out_t;

    // one queued candidate
    typedef struct packed {
        logic                          valid;
        logic [AGE_BITS-1:0]           age;
        logic signed [SAMPLE_BITS-1:0] value;
    } cand_t;

    // per-cycle control broadcast to every cell
    typedef struct packed {
        logic                          accept;
        logic                          drain;
        logic                          shift;
        logic                          clear;
        logic signed [SAMPLE_BITS-1:0] sample;
    } ctrl_t;

    // zero reads as one, anything above the cell count saturates
    function automatic logic [AGE_BITS-1:0] eff_window(input logic [WSIZE_BITS-1:0] w);
        logic [AGE_BITS-1:0] r;
        if (w == '0)
        begin
            r = AGE_BITS'(1);
        end
        else if (32'(w) > WINDOW_MAX)
        begin
            r = AGE_BITS'(WINDOW_MAX);
        end
        else
        begin
            r = AGE_BITS'(w);
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/swm_cell.sv =====
// swm_cell: one slot of the candidate queue, front of the queue at cell 0
// depends on swm_pkg
`default_nettype none

module swm_cell (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire swm_pkg::ctrl_t ctrl,
    input  wire logic          is_head,
    input  wire logic          left_keep,
    input  wire logic          right_keep,
    input  wire swm_pkg::cand_t right_cand,
    output swm_pkg::cand_t     cand,
    output logic               keep,
    output swm_pkg::cand_t     cand_upd
);

    swm_pkg::cand_t cand_reg;
    swm_pkg::cand_t cand_next;
    swm_pkg::cand_t fresh;

    // survives the new request: present and strictly smaller
    assign keep = cand_reg.valid && (cand_reg.value < ctrl.sample);

    always_comb
    begin
        fresh.valid = 1'b1;
        fresh.age   = swm_pkg::AGE_BITS'(1);
        fresh.value = ctrl.sample;

        cand_upd = cand_reg;
        if (ctrl.drain)
        begin
            cand_upd = right_cand;
        end
        else if (ctrl.accept)
        begin
            if (ctrl.shift)
            begin
                if (right_keep)
                begin
                    cand_upd     = right_cand;
                    cand_upd.age = right_cand.age + swm_pkg::AGE_BITS'(1);
                end
                else if (is_head || keep)
                begin
                    cand_upd = fresh;
                end
                else
                begin
                    cand_upd.valid = 1'b0;
                end
            end
            else
            begin
                if (keep)
                begin
                    cand_upd.age = cand_reg.age + swm_pkg::AGE_BITS'(1);
                end
                else if (left_keep)
                begin
                    cand_upd = fresh;
                end
                else
                begin
                    cand_upd.valid = 1'b0;
                end
            end
        end

        cand_next = cand_upd;
        if (ctrl.clear)
        begin
            cand_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cand_reg <= '0;
        end
        else
        begin
            cand_reg <= cand_next;
        end
    end

    assign cand = cand_reg;

endmodule

`default_nettype wire

// ===== rtl/sliding_window_minimum_core.sv =====
// sliding_window_minimum_core: top level of the sliding-window minimum filter
// depends on swm_pkg and swm_cell
`default_nettype none

// Streaming minimum over the last window_size signed samples. The candidate
// queue is a row of WINDOW_MAX cells, front at cell 0, values strictly rising
// toward the back; every cell compares itself against the incoming sample in
// the same cycle, and a request's result is valid in the output register on
// the next cycle. A result is given once window_size samples of the sequence
// have arrived, and always on a request flagged last_in, which also empties
// the queue. Results go through one output register; a request is taken only
// while that register is empty or its result is taken in the same cycle, so a
// receiver that holds off stalls the input. The user must write window_size
// through cfg_we/cfg_data only while the block is idle; the block itself does
// not enforce this. Zero acts as one and values above WINDOW_MAX act as
// WINDOW_MAX. After the window is made smaller, the first request waits while
// the queue shifts the expired candidates beyond the first out of cell 0 one
// per cycle. No clearing pass follows reset.
module sliding_window_minimum_core (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // sample channel
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire swm_pkg::in_t                     in_data,
    // result channel
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output swm_pkg::out_t                         out_data,
    // window size register
    input  wire logic                             cfg_we,
    input  wire logic [swm_pkg::WSIZE_BITS-1:0]   cfg_data
);

    localparam int N = swm_pkg::WINDOW_MAX;

    // configuration
    logic [swm_pkg::WSIZE_BITS-1:0] wsize_reg;
    logic [swm_pkg::AGE_BITS-1:0]   w_eff;

    // samples seen in this sequence, saturating at the cell count
    logic [swm_pkg::AGE_BITS-1:0]   seen_reg;
    logic [swm_pkg::AGE_BITS-1:0]   seen_next;

    // output register
    logic          out_valid_reg;
    logic          out_valid_next;
    swm_pkg::out_t out_data_reg;
    swm_pkg::out_t out_data_next;

    // cell row
    swm_pkg::cand_t cand     [N];
    swm_pkg::cand_t cand_upd [N];
    logic           keep     [N];
    swm_pkg::ctrl_t ctrl;

    logic accept;
    logic drain;
    logic front_expired;
    logic emit;

    assign w_eff = swm_pkg::eff_window(wsize_reg);

    // front candidate has left the window as of the next sample
    assign front_expired = cand[0].valid && (cand[0].age >= w_eff);
    // a second expired candidate means the window shrank: shift it out first
    assign drain = cand[1].valid && (cand[1].age >= w_eff);

    assign in_ready = !drain && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        ctrl.accept = accept;
        ctrl.drain  = drain;
        ctrl.shift  = front_expired;
        ctrl.clear  = accept && in_data.last_in;
        ctrl.sample = in_data.sample;
    end

    // cell 0 is the front; the back end sees an always-empty neighbor
    for (genvar i = 0; i < N; i++)
    begin : g_cell
        swm_pkg::cand_t rc;
        logic           rk;
        logic           lk;

        if (i == N - 1)
        begin : g_tail
            assign rc = '0;
            assign rk = 1'b0;
        end
        else
        begin : g_body
            assign rc = cand[i+1];
            assign rk = keep[i+1];
        end

        if (i == 0)
        begin : g_head
            assign lk = 1'b1;
        end
        else
        begin : g_left
            assign lk = keep[i-1];
        end

        swm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .is_head    (i == 0),
            .left_keep  (lk),
            .right_keep (rk),
            .right_cand (rc),
            .cand       (cand[i]),
            .keep       (keep[i]),
            .cand_upd   (cand_upd[i])
        );
    end

    // fill count gates the results until the window holds enough samples
    always_comb
    begin
        seen_next = seen_reg;
        if (accept && (32'(seen_reg) < N))
        begin
            seen_next = seen_reg + swm_pkg::AGE_BITS'(1);
        end
        emit = in_data.last_in || (seen_next >= w_eff);
        if (accept && in_data.last_in)
        begin
            seen_next = '0;
        end
    end

    // result is the new front of the queue
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        if (accept && emit)
        begin
            out_valid_next           = 1'b1;
            out_data_next.window_min = cand_upd[0].value;
            out_data_next.last_out   = in_data.last_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wsize_reg     <= swm_pkg::WSIZE_BITS'(1);
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                wsize_reg <= cfg_data;
            end
            seen_reg      <= seen_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

`ifndef ASSERT_OFF
    // an occupied cell 1 implies an occupied cell 0 (queue packed toward the front)
    a_packed: assert property (@(posedge clk) disable iff (!rst_n)
        cand[1].valid |-> cand[0].valid)
        else $error("candidate queue has a hole at the front");

    // the front value is strictly smaller than the value in cell 1
    a_mono: assert property (@(posedge clk) disable iff (!rst_n)
        cand[1].valid |-> (cand[0].value < cand[1].value))
        else $error("candidate queue lost its order");

    // a final sample leaves the front cell empty and the sample count at zero
    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last_in) |=> (!cand[0].valid && (seen_reg == '0)))
        else $error("queue not cleared after final sample");

    // a final sample always produces a result
    a_last_emit: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.last_in) |=> (out_valid && out_data.last_out))
        else $error("final sample gave no result");
`endif

endmodule

`default_nettype wire
